@@ hdl/i2cm_pkg.sv @@
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

  // Configuration register map
  localparam int unsigned AddrWidth   = 3;
  localparam int unsigned DataWidth   = 32;
  localparam logic        RegHalfBit  = 1'b0;
  localparam logic        RegAckTmo   = 1'b1;
  localparam logic [15:0] HalfBitRst  = 16'd100;
  localparam logic [7:0]  AckTmoRst   = 8'd121;

  // Bus byte width
  localparam int unsigned BitsPerByte = 8;

  // Raw command opcodes on the input stream
  localparam logic [2:0] OpStart   = 3'd0;
  localparam logic [2:0] OpStop    = 3'd1;
  localparam logic [2:0] OpWrite   = 3'd2;
  localparam logic [2:0] OpWaitAck = 3'd3;
  localparam logic [2:0] OpRead    = 3'd4;

  // Queue depth between front and back
  localparam int unsigned QueueDepth = 2;

  // Decoded command kind
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_WAIT_ACK,
    CMD_READ
  } cmd_kind_e;

  // One classified tick as it travels through the queue
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  tx_data;
    logic        send_ack;
    logic        sda_in;
  } tick_t;

  // Timing configuration seen by the engine
  typedef struct packed {
    logic [15:0] half_bit_ticks;
    logic [7:0]  ack_timeout_ticks;
  } cfg_t;

  // One result of the engine
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       no_ack;
  } result_t;

endpackage

@@ hdl/i2cm_front.sv @@
// Front end: accept ticks, classify their commands and queue them for the engine.
module i2cm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  // input transaction
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          cmd_valid_i,
  input  logic [2:0]    operation_i,
  input  logic [7:0]    tx_data_i,
  input  logic          send_ack_i,
  input  logic          sda_in_i,
  // queue output toward the engine
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output i2cm_pkg::tick_t q_item_o
);

  localparam int unsigned PtrW = $clog2(i2cm_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(i2cm_pkg::QueueDepth + 1);

  i2cm_pkg::tick_t           entry_q [i2cm_pkg::QueueDepth];
  logic [PtrW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]           count_q, count_d;
  i2cm_pkg::tick_t           item;
  logic                      push;
  logic                      pop;

  // Classify the command carried by this tick
  always_comb begin
    item.tx_data  = tx_data_i;
    item.send_ack = send_ack_i;
    item.sda_in   = sda_in_i;
    item.kind     = i2cm_pkg::CMD_NONE;
    if (cmd_valid_i) begin
      unique case (operation_i)
        i2cm_pkg::OpStart:   item.kind = i2cm_pkg::CMD_START;
        i2cm_pkg::OpStop:    item.kind = i2cm_pkg::CMD_STOP;
        i2cm_pkg::OpWrite:   item.kind = i2cm_pkg::CMD_WRITE;
        i2cm_pkg::OpWaitAck: item.kind = i2cm_pkg::CMD_WAIT_ACK;
        i2cm_pkg::OpRead:    item.kind = i2cm_pkg::CMD_READ;
        default:             item.kind = i2cm_pkg::CMD_NONE;
      endcase
    end
  end

  assign in_ready_o = (count_q != CntW'(i2cm_pkg::QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = entry_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(i2cm_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(i2cm_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified tick
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

endmodule

@@ hdl/i2cm_engine.sv @@
// Back end: the bus sequencer that turns queued ticks into SCL/SDA drive results.
module i2cm_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  i2cm_pkg::cfg_t    cfg_i,
  // queue side
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  i2cm_pkg::tick_t   q_item_i,
  // result transaction
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output i2cm_pkg::result_t out_res_o
);

  localparam logic [3:0] PhIdle    = 4'd0;
  localparam logic [3:0] PhSt1     = 4'd1;
  localparam logic [3:0] PhSt2     = 4'd2;
  localparam logic [3:0] PhSp1     = 4'd3;
  localparam logic [3:0] PhSp2     = 4'd4;
  localparam logic [3:0] PhWrSet   = 4'd5;
  localparam logic [3:0] PhWrHigh  = 4'd6;
  localparam logic [3:0] PhWrLow   = 4'd7;
  localparam logic [3:0] PhAckWait = 4'd8;
  localparam logic [3:0] PhRdLow   = 4'd9;
  localparam logic [3:0] PhRdHigh  = 4'd10;
  localparam logic [3:0] PhRaLow   = 4'd11;
  localparam logic [3:0] PhRaHigh  = 4'd12;
  localparam logic [3:0] PhRaEnd   = 4'd13;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] delay_q, delay_d;
  logic [3:0]  bit_idx_q, bit_idx_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  wait_q, wait_d;
  logic        ack_choice_q, ack_choice_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic [7:0]  rx_q, rx_d;
  logic        tmo_q, tmo_d;
  logic        done;
  logic [15:0] reload;
  logic [7:0]  shift_nxt;
  logic [3:0]  bit_nxt;
  logic        fire;

  logic              out_valid_q;
  i2cm_pkg::result_t out_res_q;

  // Step whenever a tick is queued and the result slot can take it
  assign fire    = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = fire;

  // A zero delay register acts as one tick
  assign reload    = (cfg_i.half_bit_ticks == '0) ? 16'd1 : cfg_i.half_bit_ticks;
  assign bit_nxt   = bit_idx_q + 1'b1;

  // Sequencer next state for one tick
  always_comb begin
    phase_d      = phase_q;
    delay_d      = delay_q;
    bit_idx_d    = bit_idx_q;
    shift_d      = shift_q;
    wait_d       = wait_q;
    ack_choice_d = ack_choice_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    rx_d         = rx_q;
    tmo_d        = tmo_q;
    done         = 1'b0;
    shift_nxt    = '0;

    if (phase_q == PhIdle) begin
      if (q_item_i.kind != i2cm_pkg::CMD_NONE) begin
        bit_idx_d = '0;
      end
      case (q_item_i.kind)
        i2cm_pkg::CMD_START: begin
          phase_d = PhSt1; scl_d = 1'b1; sda_d = 1'b1; delay_d = reload;
        end
        i2cm_pkg::CMD_STOP: begin
          phase_d = PhSp1; scl_d = 1'b1; sda_d = 1'b0; delay_d = reload;
        end
        i2cm_pkg::CMD_WRITE: begin
          shift_d = q_item_i.tx_data;
          phase_d = PhWrSet; scl_d = 1'b0; sda_d = q_item_i.tx_data[7]; delay_d = reload;
        end
        i2cm_pkg::CMD_WAIT_ACK: begin
          tmo_d = 1'b0; wait_d = '0; phase_d = PhAckWait; scl_d = 1'b1; sda_d = 1'b1;
        end
        i2cm_pkg::CMD_READ: begin
          shift_d = '0; ack_choice_d = q_item_i.send_ack;
          phase_d = PhRdLow; scl_d = 1'b0; sda_d = 1'b1; delay_d = reload;
        end
        default: begin
        end
      endcase
    end else if (phase_q == PhAckWait) begin
      // Sample SDA for the slave's ACK, give up with a stop on timeout
      if (!q_item_i.sda_in) begin
        scl_d = 1'b0; phase_d = PhIdle; done = 1'b1;
      end else if (wait_q >= cfg_i.ack_timeout_ticks) begin
        tmo_d = 1'b1; phase_d = PhSp1; scl_d = 1'b1; sda_d = 1'b0; delay_d = reload;
      end else begin
        wait_d = wait_q + 1'b1;
      end
    end else if (delay_q > 16'd1) begin
      delay_d = delay_q - 1'b1;
    end else begin
      delay_d = '0;
      unique case (phase_q)
        PhSt1: begin
          phase_d = PhSt2; scl_d = 1'b1; sda_d = 1'b0; delay_d = reload;
        end
        PhSt2: begin
          scl_d = 1'b0; phase_d = PhIdle; done = 1'b1;
        end
        PhSp1: begin
          phase_d = PhSp2; sda_d = 1'b1; delay_d = reload;
        end
        PhWrSet: begin
          phase_d = PhWrHigh; scl_d = 1'b1; delay_d = reload;
        end
        PhWrHigh: begin
          phase_d = PhWrLow; scl_d = 1'b0; delay_d = reload;
        end
        PhWrLow: begin
          shift_nxt = {shift_q[6:0], 1'b0};
          bit_idx_d = bit_nxt;
          shift_d   = shift_nxt;
          if (bit_nxt >= 4'(i2cm_pkg::BitsPerByte)) begin
            phase_d = PhIdle; done = 1'b1;
          end else begin
            phase_d = PhWrSet; scl_d = 1'b0; sda_d = shift_nxt[7]; delay_d = reload;
          end
        end
        PhRdLow: begin
          phase_d = PhRdHigh; scl_d = 1'b1; sda_d = 1'b1; delay_d = reload;
        end
        PhRdHigh: begin
          shift_d   = {shift_q[6:0], q_item_i.sda_in};
          bit_idx_d = bit_nxt;
          scl_d     = 1'b0;
          delay_d   = reload;
          if (bit_nxt >= 4'(i2cm_pkg::BitsPerByte)) begin
            phase_d = PhRaLow; sda_d = !ack_choice_q;
          end else begin
            phase_d = PhRdLow; sda_d = 1'b1;
          end
        end
        PhRaLow: begin
          phase_d = PhRaHigh; scl_d = 1'b1; delay_d = reload;
        end
        PhRaHigh: begin
          phase_d = PhRaEnd; scl_d = 1'b0; delay_d = reload;
        end
        PhRaEnd: begin
          rx_d = shift_q; phase_d = PhIdle; done = 1'b1;
        end
        default: begin
          // stop tail and unused codes
          phase_d = PhIdle; done = 1'b1;
        end
      endcase
    end
  end

  // Hold sequencer state between ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      delay_q      <= '0;
      bit_idx_q    <= '0;
      shift_q      <= '0;
      wait_q       <= '0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      rx_q         <= '0;
      tmo_q        <= 1'b0;
    end else if (fire) begin
      phase_q      <= phase_d;
      delay_q      <= delay_d;
      bit_idx_q    <= bit_idx_d;
      shift_q      <= shift_d;
      wait_q       <= wait_d;
      ack_choice_q <= ack_choice_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      rx_q         <= rx_d;
      tmo_q        <= tmo_d;
    end
  end

  // Result register toward the output stream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q.scl_level <= scl_d;
      out_res_q.sda_level <= sda_d;
      out_res_q.busy_res  <= (phase_d != PhIdle);
      out_res_q.done_res  <= done;
      out_res_q.rx_data   <= rx_d;
      out_res_q.no_ack    <= tmo_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

@@ hdl/i2c_master_bit_engine_unit.sv @@
// Top level of the I2C master bit engine: stream ports, APB registers, front and back.
// Each input transaction is one tick of the bus engine and yields exactly one result
// transaction with the SCL/SDA drive levels and status after that tick. The block takes
// one tick per clock cycle when the output side keeps up; each tick passes through the
// two-entry tick queue and then the engine, whose sequencer steps once per tick and
// registers the result. Bus delays are counted in ticks:
// half_bit_ticks at 0x0 (reset 100, zero acts as one) and ack_timeout_ticks at 0x4
// (reset 121). Write the registers only while no tick is still in flight.
module i2c_master_bit_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] tx_data, [8] send_ack, [9] sda_in, rest zero
  input  logic [3:0]  s_axis_tuser_i,  // [0] cmd_valid, [3:1] operation
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [0] scl_level, [1] sda_level, [2] busy_res,
                                       // [3] done_res, [11:4] rx_data, [12] no_ack
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [i2cm_pkg::AddrWidth-1:0] paddr,
  input  logic [i2cm_pkg::DataWidth-1:0] pwdata,
  output logic [i2cm_pkg::DataWidth-1:0] prdata,
  output logic        pready
);

  i2cm_pkg::cfg_t    cfg_q;
  i2cm_pkg::tick_t   q_item;
  i2cm_pkg::result_t res;
  logic              q_valid;
  logic              q_pop;
  logic              cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit_ticks    <= i2cm_pkg::HalfBitRst;
      cfg_q.ack_timeout_ticks <= i2cm_pkg::AckTmoRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        i2cm_pkg::RegHalfBit: cfg_q.half_bit_ticks    <= pwdata[15:0];
        i2cm_pkg::RegAckTmo:  cfg_q.ack_timeout_ticks <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (paddr[2])
      i2cm_pkg::RegHalfBit: prdata = {16'd0, cfg_q.half_bit_ticks};
      i2cm_pkg::RegAckTmo:  prdata = {24'd0, cfg_q.ack_timeout_ticks};
      default:              prdata = '0;
    endcase
  end

  i2cm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cmd_valid_i (s_axis_tuser_i[0]),
    .operation_i (s_axis_tuser_i[3:1]),
    .tx_data_i   (s_axis_tdata_i[7:0]),
    .send_ack_i  (s_axis_tdata_i[8]),
    .sda_in_i    (s_axis_tdata_i[9]),
    .q_valid_o   (q_valid),
    .q_pop_i     (q_pop),
    .q_item_o    (q_item)
  );

  i2cm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  // Pack the result fields
  assign m_axis_tdata_o = {3'd0, res.no_ack, res.rx_data, res.done_res, res.busy_res,
                           res.sda_level, res.scl_level};

endmodule

@@ bench/i2c_master_bit_engine_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the I2C master bit engine unit: directed and random bus traffic.
module i2c_master_bit_engine_unit_tb;

  localparam int unsigned AddrW         = i2cm_pkg::AddrWidth;
  localparam int unsigned DataW         = i2cm_pkg::DataWidth;
  localparam int unsigned StallLimit    = 5000;
  localparam int unsigned TicksPerPhase = 40;
  localparam int unsigned DrainCycles   = 10;
  localparam int          NeverAck      = -1;

  // Engine phases as tracked by the predictor
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_SDA,
    PH_START_SCL,
    PH_STOP_SDA,
    PH_STOP_END,
    PH_WR_SET,
    PH_WR_HIGH,
    PH_WR_LOW,
    PH_ACK_WAIT,
    PH_RD_LOW,
    PH_RD_HIGH,
    PH_ACK_LOW,
    PH_ACK_HIGH,
    PH_ACK_END
  } bus_phase_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [15:0]          s_axis_tdata_i = '0;  // [7:0] tx_data, [8] send_ack, [9] sda_in
  logic [3:0]           s_axis_tuser_i = '0;  // [0] cmd_valid, [3:1] operation
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [15:0]          m_axis_tdata_o;       // [0] scl, [1] sda, [2] busy, [3] done,
                                              // [11:4] rx_data, [12] no_ack
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrW-1:0]     paddr = '0;
  logic [DataW-1:0]     pwdata = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  // Predictor state and configuration copy
  bus_phase_e  bus_phase = PH_IDLE;
  logic [15:0] bus_delay = '0;
  logic [3:0]  bus_bit_cnt = '0;
  logic [7:0]  bus_shift = '0;
  logic [7:0]  bus_wait_cnt = '0;
  logic        bus_ack_choice = 1'b0;
  logic        bus_scl = 1'b1;
  logic        bus_sda = 1'b1;
  logic [7:0]  bus_rx = '0;
  logic        bus_no_ack = 1'b0;
  logic [15:0] cfg_half_bit = i2cm_pkg::HalfBitRst;
  logic [7:0]  cfg_ack_tmo = i2cm_pkg::AckTmoRst;

  i2cm_pkg::result_t bus_levels_q[$];
  int          err_count = 0;
  int          tick_cnt = 0;
  int          idle_cycles = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;

  i2c_master_bit_engine_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 50 MHz clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Enter a timed step: set the levels and reload the delay counter
  function automatic void enter_phase(bus_phase_e nxt, logic scl, logic sda);
    bus_phase = nxt;
    bus_scl   = scl;
    bus_sda   = sda;
    bus_delay = (cfg_half_bit == 16'd0) ? 16'd1 : cfg_half_bit;
  endfunction

  // Advance the engine by one tick and return the levels and status after it
  function automatic i2cm_pkg::result_t predict_bus_levels(logic cmd_valid, logic [2:0] op,
                                                           logic [7:0] txd, logic send_ack,
                                                           logic sda_in);
    i2cm_pkg::result_t res;
    logic              done;
    done = 1'b0;
    if (bus_phase == PH_IDLE) begin
      if (cmd_valid) begin
        bus_bit_cnt = '0;
        case (op)
          i2cm_pkg::OpStart: enter_phase(PH_START_SDA, 1'b1, 1'b1);
          i2cm_pkg::OpStop:  enter_phase(PH_STOP_SDA, 1'b1, 1'b0);
          i2cm_pkg::OpWrite: begin
            bus_shift = txd;
            enter_phase(PH_WR_SET, 1'b0, txd[7]);
          end
          i2cm_pkg::OpWaitAck: begin
            bus_no_ack   = 1'b0;
            bus_wait_cnt = '0;
            bus_phase    = PH_ACK_WAIT;
            bus_sda      = 1'b1;
            bus_scl      = 1'b1;
          end
          i2cm_pkg::OpRead: begin
            bus_shift      = '0;
            bus_ack_choice = send_ack;
            enter_phase(PH_RD_LOW, 1'b0, 1'b1);
          end
          default: ;
        endcase
      end
    end else if (bus_phase == PH_ACK_WAIT) begin
      // Low SDA is the acknowledge; a high sample past the limit gives up with a stop
      if (!sda_in) begin
        bus_scl   = 1'b0;
        bus_phase = PH_IDLE;
        done      = 1'b1;
      end else if (bus_wait_cnt >= cfg_ack_tmo) begin
        bus_no_ack = 1'b1;
        enter_phase(PH_STOP_SDA, 1'b1, 1'b0);
      end else begin
        bus_wait_cnt++;
      end
    end else if (bus_delay > 16'd1) begin
      bus_delay--;
    end else begin
      bus_delay = '0;
      case (bus_phase)
        PH_START_SDA: enter_phase(PH_START_SCL, 1'b1, 1'b0);
        PH_START_SCL: begin
          bus_scl   = 1'b0;
          bus_phase = PH_IDLE;
          done      = 1'b1;
        end
        PH_STOP_SDA: enter_phase(PH_STOP_END, bus_scl, 1'b1);
        PH_WR_SET:   enter_phase(PH_WR_HIGH, 1'b1, bus_sda);
        PH_WR_HIGH:  enter_phase(PH_WR_LOW, 1'b0, bus_sda);
        PH_WR_LOW: begin
          bus_bit_cnt++;
          bus_shift = bus_shift << 1;
          if (bus_bit_cnt >= i2cm_pkg::BitsPerByte) begin
            bus_phase = PH_IDLE;
            done      = 1'b1;
          end else begin
            enter_phase(PH_WR_SET, 1'b0, bus_shift[7]);
          end
        end
        PH_RD_LOW: enter_phase(PH_RD_HIGH, 1'b1, 1'b1);
        PH_RD_HIGH: begin
          bus_shift = {bus_shift[6:0], sda_in};
          bus_bit_cnt++;
          if (bus_bit_cnt >= i2cm_pkg::BitsPerByte) begin
            enter_phase(PH_ACK_LOW, 1'b0, ~bus_ack_choice);
          end else begin
            enter_phase(PH_RD_LOW, 1'b0, 1'b1);
          end
        end
        PH_ACK_LOW:  enter_phase(PH_ACK_HIGH, 1'b1, bus_sda);
        PH_ACK_HIGH: enter_phase(PH_ACK_END, 1'b0, bus_sda);
        PH_ACK_END: begin
          bus_rx    = bus_shift;
          bus_phase = PH_IDLE;
          done      = 1'b1;
        end
        default: begin
          bus_phase = PH_IDLE;
          done      = 1'b1;
        end
      endcase
    end
    res.scl_level = bus_scl;
    res.sda_level = bus_sda;
    res.busy_res  = (bus_phase != PH_IDLE);
    res.done_res  = done;
    res.rx_data   = bus_rx;
    res.no_ack    = bus_no_ack;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ERROR %s expected %0h actual %0h", $time, name, exp_val, act_val);
      err_count++;
    end
  endfunction

  // Drive one tick transaction, wait for it to be taken, and record its expected result
  task automatic send_tick(input logic cmd_valid, input logic [2:0] op, input logic [7:0] txd,
                           input logic send_ack, input logic sda_in);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {6'd0, sda_in, send_ack, txd};
    s_axis_tuser_i  = {op, cmd_valid};
    do @(posedge clk_i); while (!s_axis_tready_o);
    bus_levels_q.push_back(predict_bus_levels(cmd_valid, op, txd, send_ack, sda_in));
    tick_cnt++;
  endtask

  // Issue a command and tick until the engine is idle again. The slave pulls SDA low
  // from tick ack_at of an ACK wait on; elsewhere SDA is high with sda_one_pct chance.
  task automatic run_command(input logic [2:0] op, input logic [7:0] txd, input logic send_ack,
                             input int ack_at, input int sda_one_pct, input int noise_pct);
    int   n;
    logic sda;
    logic noise;
    send_tick(1'b1, op, txd, send_ack, 1'($urandom_range(1)));
    n = 0;
    while (bus_phase != PH_IDLE) begin
      n++;
      if (bus_phase == PH_ACK_WAIT) sda = !(ack_at >= 0 && n >= ack_at);
      else sda = ($urandom_range(99) < sda_one_pct);
      noise = ($urandom_range(99) < noise_pct);
      send_tick(noise, 3'($urandom_range(7)), 8'($urandom), 1'($urandom), sda);
    end
  endtask

  // Hold off the input until every expected result has come back
  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (bus_levels_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [DataW-1:0] wdata,
                            output logic [DataW-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_timing_regs();
    logic [DataW-1:0] rd;
    apb_access(1'b0, {i2cm_pkg::RegHalfBit, 2'b00}, '0, rd);
    check_field("half_bit_ticks", 32'(cfg_half_bit), 32'(rd));
    apb_access(1'b0, {i2cm_pkg::RegAckTmo, 2'b00}, '0, rd);
    check_field("ack_timeout_ticks", 32'(cfg_ack_tmo), 32'(rd));
  endtask

  // Reprogram both timing registers once nothing is in flight
  task automatic set_timing(input logic [15:0] half, input logic [7:0] tmo);
    logic [DataW-1:0] rd;
    wait_drain();
    apb_access(1'b1, {i2cm_pkg::RegHalfBit, 2'b00}, DataW'(half), rd);
    cfg_half_bit = half;
    apb_access(1'b1, {i2cm_pkg::RegAckTmo, 2'b00}, DataW'(tmo), rd);
    cfg_ack_tmo = tmo;
    check_timing_regs();
  endtask

  // Slave answers within the limit, right at it, or never
  function automatic int ack_delay();
    if ($urandom_range(99) < 75) return $urandom_range(1, int'(cfg_ack_tmo) + 1);
    return NeverAck;
  endfunction

  // Start, address byte, then up to two reads or writes, then stop unless the ACK timed out
  task automatic random_transfer();
    run_command(i2cm_pkg::OpStart, 8'($urandom), 1'($urandom), NeverAck, 50, 5);
    run_command(i2cm_pkg::OpWrite, 8'($urandom), 1'($urandom), NeverAck, 50, 5);
    run_command(i2cm_pkg::OpWaitAck, 8'($urandom), 1'($urandom), ack_delay(), 50, 5);
    repeat ($urandom_range(0, 2)) begin
      if (bus_no_ack) break;
      if ($urandom_range(1)) begin
        run_command(i2cm_pkg::OpWrite, 8'($urandom), 1'($urandom), NeverAck, 50, 5);
        run_command(i2cm_pkg::OpWaitAck, 8'($urandom), 1'($urandom), ack_delay(), 50, 5);
      end else begin
        run_command(i2cm_pkg::OpRead, 8'($urandom), 1'($urandom), NeverAck, 50, 5);
      end
    end
    if (!bus_no_ack) begin
      run_command(i2cm_pkg::OpStop, 8'($urandom), 1'($urandom), NeverAck, 50, 5);
    end
  endtask

  // Ticks with arbitrary content, then quiet ticks until the engine settles
  task automatic random_noise();
    repeat ($urandom_range(1, 8)) begin
      send_tick(($urandom_range(99) < 25), 3'($urandom_range(7)), 8'($urandom),
                1'($urandom), 1'($urandom));
    end
    while (bus_phase != PH_IDLE) begin
      send_tick(1'b0, 3'($urandom_range(7)), 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // Reset timing values: start, ACK wait that times out into a stop
  task automatic test_reset_timing();
    check_timing_regs();
    run_command(i2cm_pkg::OpStart, 8'h00, 1'b0, NeverAck, 50, 0);
    run_command(i2cm_pkg::OpWaitAck, 8'h00, 1'b0, NeverAck, 50, 0);
  endtask

  // Every operation, field extremes, ACK boundaries, ignored and unknown commands
  task automatic test_directed_ops();
    src_idle_pct   = 10;
    sink_stall_pct = 10;
    set_timing(16'd1, 8'd1);
    run_command(i2cm_pkg::OpStart, 8'h00, 1'b0, NeverAck, 50, 0);
    run_command(i2cm_pkg::OpWrite, 8'hFF, 1'b1, NeverAck, 50, 0);
    run_command(i2cm_pkg::OpWrite, 8'h00, 1'b0, NeverAck, 50, 0);
    run_command(i2cm_pkg::OpWaitAck, 8'h00, 1'b0, 1, 50, 0);
    run_command(i2cm_pkg::OpWaitAck, 8'h00, 1'b0, NeverAck, 50, 0);
    run_command(i2cm_pkg::OpWaitAck, 8'h00, 1'b0, 2, 50, 0);
    run_command(i2cm_pkg::OpRead, 8'h00, 1'b1, NeverAck, 100, 0);
    run_command(i2cm_pkg::OpRead, 8'hFF, 1'b0, NeverAck, 0, 0);
    run_command(i2cm_pkg::OpStop, 8'h00, 1'b0, NeverAck, 50, 0);
    for (int op = i2cm_pkg::OpRead + 1; op < 8; op++) begin
      run_command(3'(op), 8'hFF, 1'b1, NeverAck, 50, 0);
    end
    // commands arriving while busy are dropped
    run_command(i2cm_pkg::OpStart, 8'h00, 1'b0, NeverAck, 50, 100);
    // zero delay behaves as one, longest ACK wait
    set_timing(16'd0, 8'd255);
    run_command(i2cm_pkg::OpStart, 8'h00, 1'b0, NeverAck, 50, 0);
    run_command(i2cm_pkg::OpWaitAck, 8'h00, 1'b0, NeverAck, 50, 0);
  endtask

  // Bus delay that needs the upper byte of the counter, run without idling on either side
  task automatic test_timing_extremes();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_timing(16'h0100, 8'd1);
    run_command(i2cm_pkg::OpStart, 8'h00, 1'b0, NeverAck, 50, 0);
  endtask

  // Random transfers and noise under each idling mix, retimed between transfers
  task automatic test_random_traffic();
    int src_pct[4]  = '{0, 85, 0, 10};
    int sink_pct[4] = '{0, 0, 85, 10};
    int start_cnt;
    for (int ph = 0; ph < 4; ph++) begin
      wait_drain();
      src_idle_pct   = src_pct[ph];
      sink_stall_pct = sink_pct[ph];
      start_cnt      = tick_cnt;
      while (tick_cnt - start_cnt < TicksPerPhase) begin
        set_timing(($urandom_range(99) < 70) ? 16'($urandom_range(1, 2))
                                             : 16'($urandom_range(0, 6)),
                   ($urandom_range(99) < 90) ? 8'($urandom_range(1, 6))
                                             : 8'($urandom_range(200, 255)));
        if ($urandom_range(99) < 85) random_transfer();
        else random_noise();
      end
    end
  endtask

  // Randomly stall the result stream
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    i2cm_pkg::result_t exp_res;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (bus_levels_q.size() == 0) begin
        $display("%0t ERROR unexpected result expected none actual %h", $time, m_axis_tdata_o);
        err_count++;
      end else begin
        exp_res = bus_levels_q.pop_front();
        check_field("scl_level", 32'(exp_res.scl_level), 32'(m_axis_tdata_o[0]));
        check_field("sda_level", 32'(exp_res.sda_level), 32'(m_axis_tdata_o[1]));
        check_field("busy_res", 32'(exp_res.busy_res), 32'(m_axis_tdata_o[2]));
        check_field("done_res", 32'(exp_res.done_res), 32'(m_axis_tdata_o[3]));
        check_field("rx_data", 32'(exp_res.rx_data), 32'(m_axis_tdata_o[11:4]));
        check_field("no_ack", 32'(exp_res.no_ack), 32'(m_axis_tdata_o[12]));
      end
    end
  end

  // Abort when no transaction moves on either stream for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("%0t ERROR timeout with %0d results outstanding", $time, bus_levels_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_timing();
    test_directed_ops();
    test_timing_extremes();
    test_random_traffic();
    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/i2cm_pkg.sv
hdl/i2cm_front.sv
hdl/i2cm_engine.sv
hdl/i2c_master_bit_engine_unit.sv
bench/i2c_master_bit_engine_unit_tb.sv
